// File: rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

   // Field and register widths
   localparam int PIX_W  = 8;
   localparam int DIM_W  = 13;
   localparam int ROW_W  = 12;
   localparam int POS_W  = 12;
   localparam int GRAD_W = 11;

   // Square root unit: sum of squares fits 21 bits, root fits 11 bits
   localparam int SUM_W      = 21;
   localparam int ROOT_W     = 11;
   localparam int SQRT_STEPS = 11;
   localparam int STEP_W     = 4;

   // Register reset values and limits
   localparam logic [DIM_W-1:0] DIM_RESET    = 13'd4096;
   localparam logic [DIM_W-1:0] DIM_MIN      = 13'd3;
   localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam logic [ROOT_W-1:0] MAG_CLIP    = 11'd255;

   // Register indexes, taken from paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ROOT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/sobel_edge_magnitude.sv
// Top level: 3x3 Sobel gradient magnitude over a raster pixel stream.
//
//  Channel   Direction  Handshake                Carries
//  req_*     in         req_valid / req_stall    one grey pixel per item
//  rsp_*     out        rsp_valid / rsp_stall    magnitude, center row/col, frame_last
//  csr (APB) in         psel/penable/pready      image_width @0x0, image_height @0x4
//
// A pixel that makes no result passes ST_IDLE (line memory read) and ST_READ (write back);
// one that makes a result goes on through ST_SQUARE, ST_ROOT and ST_EMIT; the 11-step square root unit runs in ST_ROOT.
// One item is in work at a time; req_stall is low only when the sequencer is idle.
// A finished result waits in the output register while the next pixel is taken.
// Reset clears the window, the counters and the configuration registers; the line memory is not
// cleared, its first two rows are written before any result reads them.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   // pixel input
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sem_pkg::PIX_W-1:0]   req_pixel,
   // magnitude output
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sem_pkg::PIX_W-1:0]   rsp_magnitude,
   output logic [sem_pkg::ROW_W-1:0]   rsp_center_row,
   output logic [sem_pkg::POS_W-1:0]   rsp_center_col,
   output logic                        rsp_frame_last,
   // configuration
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   // Configuration registers
   logic [sem_pkg::DIM_W-1:0] width_ff;
   logic [sem_pkg::DIM_W-1:0] height_ff;
   logic                      cfg_write;

   // Sequencer
   sem_pkg::state_type state_ff;
   sem_pkg::state_type state_in;
   logic accept;
   logic mem_wr_en;
   logic sqrt_start;
   logic rsp_load;
   logic rsp_free;

   // Counters and effective geometry
   logic [CW-1:0]              col_ff;
   logic [sem_pkg::ROW_W-1:0]  row_ff;
   logic [WW-1:0]              w_eff;
   logic [sem_pkg::DIM_W-1:0]  h_eff;
   logic [WW-1:0]              c_ext;
   logic [WW-1:0]              c_eff;
   logic [WW-1:0]              c_inc;
   logic [sem_pkg::DIM_W-1:0]  r_ext;
   logic [sem_pkg::DIM_W-1:0]  r_eff;
   logic [sem_pkg::DIM_W-1:0]  r_inc;
   logic [CW-1:0]              col_idx;

   // Per-item registers
   logic [sem_pkg::PIX_W-1:0]  pixel_ff;
   logic [CW-1:0]              addr_ff;
   logic                       emit_ff;
   logic [sem_pkg::ROW_W-1:0]  out_row_ff;
   logic [sem_pkg::POS_W-1:0]  out_col_ff;
   logic                       out_last_ff;

   // Window and line memory
   logic [sem_pkg::PIX_W-1:0]  win_ff [6];
   logic [2*sem_pkg::PIX_W-1:0] mem_rd_data;
   logic [sem_pkg::PIX_W-1:0]  top_new;
   logic [sem_pkg::PIX_W-1:0]  mid_new;

   // Gradients
   logic signed [sem_pkg::GRAD_W+1:0] gx_full;
   logic signed [sem_pkg::GRAD_W+1:0] gy_full;
   logic signed [sem_pkg::GRAD_W-1:0] gx_ff;
   logic signed [sem_pkg::GRAD_W-1:0] gy_ff;
   logic signed [2*sem_pkg::GRAD_W-1:0] gx_sq;
   logic signed [2*sem_pkg::GRAD_W-1:0] gy_sq;
   logic [sem_pkg::SUM_W-1:0]  sum_sq;

   // Square root
   logic                       sqrt_done;
   logic [sem_pkg::ROOT_W-1:0] sqrt_root;

   // Output register
   logic                       rsp_valid_ff;
   logic [sem_pkg::PIX_W-1:0]  rsp_mag_ff;
   logic [sem_pkg::ROW_W-1:0]  rsp_row_ff;
   logic [sem_pkg::POS_W-1:0]  rsp_col_ff;
   logic                       rsp_last_ff;

   // APB port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      case (paddr[2])
         sem_pkg::REG_WIDTH:  prdata = 32'(width_ff);
         sem_pkg::REG_HEIGHT: prdata = 32'(height_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::DIM_RESET;
         height_ff <= sem_pkg::DIM_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == sem_pkg::REG_WIDTH) begin
            width_ff <= pwdata[sem_pkg::DIM_W-1:0];
         end else begin
            height_ff <= pwdata[sem_pkg::DIM_W-1:0];
         end
      end
   end

   // Clamp geometry and counters
   always_comb begin
      if (width_ff < sem_pkg::DIM_MIN) begin
         w_eff = WW'(sem_pkg::DIM_MIN);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end

      if (height_ff < sem_pkg::DIM_MIN) begin
         h_eff = sem_pkg::DIM_MIN;
      end else if (height_ff > sem_pkg::HEIGHT_LIMIT) begin
         h_eff = sem_pkg::HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end

      c_ext = WW'(col_ff);
      c_eff = (c_ext >= w_eff) ? w_eff - 1'b1 : c_ext;
      c_inc = c_eff + 1'b1;
      col_idx = CW'(c_eff);

      r_ext = sem_pkg::DIM_W'(row_ff);
      r_eff = (r_ext >= h_eff) ? h_eff - 1'b1 : r_ext;
      r_inc = r_eff + 1'b1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sem_pkg::ST_IDLE:   if (req_valid) state_in = sem_pkg::ST_READ;
         sem_pkg::ST_READ:   state_in = emit_ff ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
         sem_pkg::ST_SQUARE: state_in = sem_pkg::ST_ROOT;
         sem_pkg::ST_ROOT:   if (sqrt_done) state_in = sem_pkg::ST_EMIT;
         sem_pkg::ST_EMIT:   if (rsp_free) state_in = sem_pkg::ST_IDLE;
         default:            state_in = sem_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_stall  = 1'b1;
      accept     = 1'b0;
      mem_wr_en  = 1'b0;
      sqrt_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         sem_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         sem_pkg::ST_READ:   mem_wr_en  = 1'b1;
         sem_pkg::ST_SQUARE: sqrt_start = 1'b1;
         sem_pkg::ST_ROOT:   ;
         sem_pkg::ST_EMIT:   rsp_load   = rsp_free;
         default:            ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Raster counters; a register write restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (c_inc >= w_eff) begin
            col_ff <= '0;
            row_ff <= (r_inc >= h_eff) ? '0 : sem_pkg::ROW_W'(r_inc);
         end else begin
            col_ff <= CW'(c_inc);
            row_ff <= sem_pkg::ROW_W'(r_eff);
         end
      end
   end

   // Capture the item and its output position
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff    <= req_pixel;
         addr_ff     <= col_idx;
         emit_ff     <= (r_eff >= sem_pkg::DIM_W'(2)) && (c_eff >= WW'(2));
         out_row_ff  <= sem_pkg::ROW_W'(r_eff - 1'b1);
         out_col_ff  <= sem_pkg::POS_W'(c_eff - 1'b1);
         out_last_ff <= (r_eff == h_eff - 1'b1) && (c_eff == w_eff - 1'b1);
      end
   end

   // Line memory: upper row in the high byte, middle row in the low byte
   sem_ram #(
      .WIDTH (2*sem_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({mid_new, pixel_ff}),
      .rd_en   (accept),
      .rd_addr (col_idx),
      .rd_data (mem_rd_data)
   );

   assign top_new = mem_rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
   assign mid_new = mem_rd_data[sem_pkg::PIX_W-1:0];

   // Sobel responses over the window and the new column
   always_comb begin
      gx_full = $signed({5'b0, top_new})  - $signed({5'b0, win_ff[0]})
              + ($signed({5'b0, mid_new}) <<< 1) - ($signed({5'b0, win_ff[2]}) <<< 1)
              + $signed({5'b0, pixel_ff}) - $signed({5'b0, win_ff[4]});
      gy_full = $signed({5'b0, win_ff[0]}) + ($signed({5'b0, win_ff[1]}) <<< 1)
              + $signed({5'b0, top_new})
              - $signed({5'b0, win_ff[4]}) - ($signed({5'b0, win_ff[5]}) <<< 1)
              - $signed({5'b0, pixel_ff});
   end

   // Window shift and gradient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (mem_wr_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= top_new;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_new;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         gx_ff <= sem_pkg::GRAD_W'(gx_full);
         gy_ff <= sem_pkg::GRAD_W'(gy_full);
      end
   end

   // Sum of squares feeds the root unit
   assign gx_sq  = gx_ff * gx_ff;
   assign gy_sq  = gy_ff * gy_ff;
   assign sum_sq = sem_pkg::SUM_W'(gx_sq) + sem_pkg::SUM_W'(gy_sq);

   sem_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sum_sq),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mag_ff  <= (sqrt_root > sem_pkg::MAG_CLIP) ? sem_pkg::PIX_W'(sem_pkg::MAG_CLIP)
                                                        : sem_pkg::PIX_W'(sqrt_root);
         rsp_row_ff  <= out_row_ff;
         rsp_col_ff  <= out_col_ff;
         rsp_last_ff <= out_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// File: rtl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sem_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module sem_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sem_pkg::SUM_W-1:0]   operand,
   output logic                        done,
   output logic [sem_pkg::ROOT_W-1:0]  root
);

   logic                            busy_ff;
   logic                            done_ff;
   logic [sem_pkg::STEP_W-1:0]      step_ff;
   logic [sem_pkg::SUM_W-1:0]       rem_ff;
   logic [sem_pkg::SUM_W-1:0]       rem_in;
   logic [sem_pkg::SUM_W:0]         root_ff;
   logic [sem_pkg::SUM_W:0]         root_in;
   logic [sem_pkg::SUM_W:0]         bit_val;
   logic [sem_pkg::SUM_W:0]         trial;

   // One digit step: trial subtract of root + 4^step
   always_comb begin
      bit_val = (sem_pkg::SUM_W+1)'(1) << {step_ff, 1'b0};
      trial   = root_ff + bit_val;
      if ({1'b0, rem_ff} >= trial) begin
         rem_in  = sem_pkg::SUM_W'({1'b0, rem_ff} - trial);
         root_in = (root_ff >> 1) + bit_val;
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= sem_pkg::STEP_W'(sem_pkg::SQRT_STEPS - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= operand;
         root_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = sem_pkg::ROOT_W'(root_ff);

endmodule
